[src/tile_chunk_cache_manager_unit_macros.svh]
// assertion macros for the tile chunk cache manager
// used by the rtl files that carry concurrent checks
`ifndef TILE_CHUNK_CACHE_MANAGER_UNIT_MACROS_SVH
`define TILE_CHUNK_CACHE_MANAGER_UNIT_MACROS_SVH

`ifndef ASSERT_OFF
// check that holds only outside reset
`define TCCM_ASSERT(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);
// check that also holds during reset
`define TCCM_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define TCCM_ASSERT(lbl, clk, rstn, prop, msg)
`define TCCM_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif

`endif

[src/tccm_pkg.sv]
// shared constants and types for the tile chunk cache manager
// no dependencies
package tccm_pkg;

    localparam int ENTRY_COUNT_DEF = 36;
    localparam int MODE_W = 2;
    localparam int GEN_W  = 32;
    localparam int SEQ_W  = 64;
    localparam int COORD_W = 16;
    localparam int TAG_W  = 32;
    localparam int SIG_W  = 64;
    localparam int SLOT_W = 6;
    localparam int CNT_W  = 6;

    localparam logic [MODE_W-1:0] MODE_BEGIN = 2'd0;
    localparam logic [MODE_W-1:0] MODE_REQ   = 2'd1;
    localparam logic [MODE_W-1:0] MODE_END   = 2'd2;

    typedef struct packed {
        logic [TAG_W-1:0] tag;
        logic [SIG_W-1:0] sig;
        logic [SEQ_W-1:0] seen;
    } t_entry;

    typedef struct packed {
        logic [MODE_W-1:0]         mode;
        logic [GEN_W-1:0]          map_generation;
        logic [GEN_W-1:0]          rules_generation;
        logic [SEQ_W-1:0]          sequence_req;
        logic signed [COORD_W-1:0] chunk_x;
        logic signed [COORD_W-1:0] chunk_y;
        logic [SIG_W-1:0]          content_signature;
        logic                      force_dirty;
    } t_item;

    // outcome of one lookup scan
    typedef struct packed {
        logic hit;
        logic none;
    } t_scan_flags;

endpackage

[src/tccm_ifs.sv]
// valid/ready channel interfaces for requests and results
// depends on tccm_pkg
interface tccm_in_if;
    import tccm_pkg::*;

    logic                      valid;
    logic                      ready;
    logic [MODE_W-1:0]         mode;
    logic [GEN_W-1:0]          map_generation;
    logic [GEN_W-1:0]          rules_generation;
    logic [SEQ_W-1:0]          sequence_req;
    logic signed [COORD_W-1:0] chunk_x;
    logic signed [COORD_W-1:0] chunk_y;
    logic [SIG_W-1:0]          content_signature;
    logic                      force_dirty;

    modport source (
        output valid, mode, map_generation, rules_generation, sequence_req,
               chunk_x, chunk_y, content_signature, force_dirty,
        input  ready
    );
    modport sink (
        input  valid, mode, map_generation, rules_generation, sequence_req,
               chunk_x, chunk_y, content_signature, force_dirty,
        output ready
    );
endinterface

interface tccm_out_if;
    import tccm_pkg::*;

    logic              valid;
    logic              ready;
    logic [SLOT_W-1:0] slot;
    logic              rebuild;
    logic              no_slot;
    logic              generation_flush;
    logic [CNT_W-1:0]  resident_count;
    logic [CNT_W-1:0]  active_count;

    modport source (
        output valid, slot, rebuild, no_slot, generation_flush,
               resident_count, active_count,
        input  ready
    );
    modport sink (
        input  valid, slot, rebuild, no_slot, generation_flush,
               resident_count, active_count,
        output ready
    );
endinterface

[src/tccm_mem.sv]
// entry store: one write port, one read port with registered data
// depends on nothing but its parameters
module tccm_mem #(
    parameter int DEPTH = 36,
    parameter int WIDTH = 160,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

[src/tccm_scan.sv]
// lookup scan: walks the entry store once, tracking the first tag hit,
// the first free slot and the oldest inactive slot; depends on tccm_pkg
module tccm_scan #(
    parameter int ENTRY_COUNT = tccm_pkg::ENTRY_COUNT_DEF,
    localparam int IW = $clog2(ENTRY_COUNT)
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_start,
    input  logic [tccm_pkg::TAG_W-1:0] i_tag,
    input  logic [ENTRY_COUNT-1:0]    i_valid,
    input  logic [ENTRY_COUNT-1:0]    i_active,
    output logic                      o_rd_en,
    output logic [IW-1:0]             o_rd_addr,
    input  tccm_pkg::t_entry          i_rd_data,
    output logic                      o_done,
    output tccm_pkg::t_scan_flags     o_flags,
    output logic [IW-1:0]             o_found_idx,
    output logic [tccm_pkg::SIG_W-1:0] o_hit_sig
);
    import tccm_pkg::*;

    localparam logic [IW-1:0] LAST_IDX = IW'(ENTRY_COUNT - 1);

    logic            r_issuing;
    logic [IW-1:0]   r_ridx;
    logic            r_cv;
    logic            r_clast;
    logic [IW-1:0]   r_cidx;
    logic            r_done;

    logic            r_hit;
    logic [IW-1:0]   r_hit_idx;
    logic [SIG_W-1:0] r_hit_sig;
    logic            r_free;
    logic [IW-1:0]   r_free_idx;
    logic            r_old;
    logic [IW-1:0]   r_old_idx;
    logic [SEQ_W-1:0] r_old_seen;

    logic            c_v;
    logic            c_a;

    assign o_rd_en   = r_issuing;
    assign o_rd_addr = r_ridx;
    assign c_v = i_valid[r_cidx];
    assign c_a = i_active[r_cidx];

    // address issue and compare stage control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_issuing <= 1'b0;
            r_ridx    <= '0;
            r_cv      <= 1'b0;
            r_clast   <= 1'b0;
            r_done    <= 1'b0;
        end else begin
            r_cv    <= r_issuing;
            r_clast <= r_issuing && (r_ridx == LAST_IDX);
            r_done  <= r_cv && r_clast;
            if (i_start) begin
                r_issuing <= 1'b1;
                r_ridx    <= '0;
            end else if (r_issuing) begin
                if (r_ridx == LAST_IDX) begin
                    r_issuing <= 1'b0;
                end else begin
                    r_ridx <= r_ridx + IW'(1);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_cidx <= r_ridx;
    end

    // trackers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hit  <= 1'b0;
            r_free <= 1'b0;
            r_old  <= 1'b0;
        end else if (i_start) begin
            r_hit  <= 1'b0;
            r_free <= 1'b0;
            r_old  <= 1'b0;
        end else if (r_cv) begin
            if (c_v && (i_rd_data.tag == i_tag) && !r_hit) begin
                r_hit     <= 1'b1;
                r_hit_idx <= r_cidx;
                r_hit_sig <= i_rd_data.sig;
            end
            if (!c_v && !r_free) begin
                r_free     <= 1'b1;
                r_free_idx <= r_cidx;
            end
            // strict compare keeps the lowest slot on a tie
            if (c_v && !c_a && (!r_old || (i_rd_data.seen < r_old_seen))) begin
                r_old      <= 1'b1;
                r_old_idx  <= r_cidx;
                r_old_seen <= i_rd_data.seen;
            end
        end
    end

    always_comb begin
        o_flags.hit  = r_hit;
        o_flags.none = !r_hit && !r_free && !r_old;
        if (r_hit) begin
            o_found_idx = r_hit_idx;
        end else if (r_free) begin
            o_found_idx = r_free_idx;
        end else begin
            o_found_idx = r_old_idx;
        end
    end

    assign o_hit_sig = r_hit_sig;
    assign o_done    = r_done;

endmodule

[src/tile_chunk_cache_manager_unit.sv]
// Tile chunk cache manager: fully associative cache of chunk slots with
// replacement of the oldest inactive slot.
// Channels: i_in carries one transaction per item (mode 0 begin sync,
// 1 chunk request, 2 end sync); o_out returns exactly one result per item,
// in order. Both use valid/ready; a transaction moves when both are high.
// Begin, end and unused-mode items go from the item register through the done
// state into the output register. A request first scans every slot through
// the one-read-port entry store, one slot per cycle, and then passes through
// the done state into the output register.
// Throughput: one item at a time; a new item is accepted in the cycle after
// the previous result has been loaded into the output register.
// A result waiting in the output register does not block acceptance of the
// next item; only loading the following result waits for o_out.ready.
// Reset (synchronous, active low): input held not ready, all slots invalid and
// inactive, held generations and sequence zero, counts zero. Valid and active
// marks live in flip-flops, so no clearing pass is needed; entry store data
// is only used for slots whose valid mark is set.
// Depends on tccm_pkg, tccm_ifs, tccm_mem, tccm_scan and the assertion macros header.
`include "tile_chunk_cache_manager_unit_macros.svh"

module tile_chunk_cache_manager_unit #(
    parameter int ENTRY_COUNT = tccm_pkg::ENTRY_COUNT_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    tccm_in_if.sink     i_in,
    tccm_out_if.source  o_out
);
    import tccm_pkg::*;

    localparam int IW = $clog2(ENTRY_COUNT);
    localparam int CW = $clog2(ENTRY_COUNT + 1);
    localparam int ENTRY_W = $bits(t_entry);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_SCAN = 2'd1;
    localparam logic [1:0] ST_DONE = 2'd2;

    logic [1:0]             r_state;
    t_item                  r_item;
    logic [ENTRY_COUNT-1:0] r_valid;
    logic [ENTRY_COUNT-1:0] r_active;
    logic [CW-1:0]          r_res_cnt;
    logic [CW-1:0]          r_act_cnt;
    logic [GEN_W-1:0]       r_held_mg;
    logic [GEN_W-1:0]       r_held_rg;
    logic [SEQ_W-1:0]       r_seq;

    logic                   r_out_valid;
    logic [SLOT_W-1:0]      r_out_slot;
    logic                   r_out_rebuild;
    logic                   r_out_no_slot;
    logic                   r_out_flush;
    logic [CNT_W-1:0]       r_out_res;
    logic [CNT_W-1:0]       r_out_act;

    logic                   in_fire;
    logic                   done_fire;
    logic                   scan_start;
    logic                   scan_done;
    t_scan_flags            scan_flags;
    logic [IW-1:0]          found_idx;
    logic [SIG_W-1:0]       hit_sig;
    logic                   rd_en;
    logic [IW-1:0]          rd_addr;
    logic [ENTRY_W-1:0]     mem_rdata;
    t_entry                 rd_entry;
    t_entry                 wr_entry;
    logic                   mem_we;
    logic [TAG_W-1:0]       req_tag;
    logic                   gen_change;
    logic                   found_valid;
    logic                   found_active;

    logic [SLOT_W-1:0]      n_slot;
    logic                   n_rebuild;
    logic                   n_no_slot;
    logic                   n_flush;
    logic [CNT_W-1:0]       n_res;
    logic [CNT_W-1:0]       n_act;

    assign i_in.ready = i_rst_n && (r_state == ST_IDLE);
    assign in_fire    = i_in.valid && i_in.ready;
    assign scan_start = in_fire && (i_in.mode == MODE_REQ);
    assign done_fire  = (r_state == ST_DONE) && (!r_out_valid || o_out.ready);

    assign req_tag      = {r_item.chunk_x, r_item.chunk_y};
    assign gen_change   = (r_item.map_generation != r_held_mg) ||
                          (r_item.rules_generation != r_held_rg);
    assign found_valid  = r_valid[found_idx];
    assign found_active = r_active[found_idx];

    assign mem_we = done_fire && (r_item.mode == MODE_REQ) && !scan_flags.none;
    assign wr_entry.tag  = req_tag;
    assign wr_entry.sig  = r_item.content_signature;
    assign wr_entry.seen = r_seq;
    assign rd_entry = mem_rdata;

    tccm_mem #(
        .DEPTH (ENTRY_COUNT),
        .WIDTH (ENTRY_W)
    ) u_mem (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (found_idx),
        .i_wdata (wr_entry),
        .i_re    (rd_en),
        .i_raddr (rd_addr),
        .o_rdata (mem_rdata)
    );

    tccm_scan #(
        .ENTRY_COUNT (ENTRY_COUNT)
    ) u_scan (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (scan_start),
        .i_tag       (req_tag),
        .i_valid     (r_valid),
        .i_active    (r_active),
        .o_rd_en     (rd_en),
        .o_rd_addr   (rd_addr),
        .i_rd_data   (rd_entry),
        .o_done      (scan_done),
        .o_flags     (scan_flags),
        .o_found_idx (found_idx),
        .o_hit_sig   (hit_sig)
    );

    // sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            case (r_state)
                ST_IDLE: begin
                    if (in_fire) begin
                        r_state <= (i_in.mode == MODE_REQ) ? ST_SCAN : ST_DONE;
                    end
                end
                ST_SCAN: begin
                    if (scan_done) begin
                        r_state <= ST_DONE;
                    end
                end
                ST_DONE: begin
                    if (done_fire) begin
                        r_state <= ST_IDLE;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_item.mode              <= i_in.mode;
            r_item.map_generation    <= i_in.map_generation;
            r_item.rules_generation  <= i_in.rules_generation;
            r_item.sequence_req      <= i_in.sequence_req;
            r_item.chunk_x           <= i_in.chunk_x;
            r_item.chunk_y           <= i_in.chunk_y;
            r_item.content_signature <= i_in.content_signature;
            r_item.force_dirty       <= i_in.force_dirty;
        end
    end

    // slot marks, counts and held sync state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid   <= '0;
            r_active  <= '0;
            r_res_cnt <= '0;
            r_act_cnt <= '0;
            r_held_mg <= '0;
            r_held_rg <= '0;
            r_seq     <= '0;
        end else if (done_fire) begin
            case (r_item.mode)
                MODE_BEGIN: begin
                    if (gen_change) begin
                        r_valid   <= '0;
                        r_res_cnt <= '0;
                        r_held_mg <= r_item.map_generation;
                        r_held_rg <= r_item.rules_generation;
                    end
                    r_active  <= '0;
                    r_act_cnt <= '0;
                    r_seq     <= r_item.sequence_req;
                end
                MODE_REQ: begin
                    if (!scan_flags.none) begin
                        r_valid[found_idx]  <= 1'b1;
                        r_active[found_idx] <= 1'b1;
                        if (!found_valid) begin
                            r_res_cnt <= r_res_cnt + CW'(1);
                        end
                        if (!found_active) begin
                            r_act_cnt <= r_act_cnt + CW'(1);
                        end
                    end
                end
                default: begin
                end
            endcase
        end
    end

    // result formation
    always_comb begin
        n_slot    = '0;
        n_rebuild = 1'b0;
        n_no_slot = 1'b0;
        n_flush   = 1'b0;
        n_res     = '0;
        n_act     = '0;
        case (r_item.mode)
            MODE_BEGIN: begin
                n_flush = gen_change;
            end
            MODE_REQ: begin
                if (scan_flags.none) begin
                    n_no_slot = 1'b1;
                end else begin
                    n_slot    = SLOT_W'(found_idx);
                    n_rebuild = !scan_flags.hit ||
                                (hit_sig != r_item.content_signature) ||
                                r_item.force_dirty;
                end
            end
            MODE_END: begin
                n_res = CNT_W'(r_res_cnt);
                n_act = CNT_W'(r_act_cnt);
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (done_fire) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (done_fire) begin
            r_out_slot    <= n_slot;
            r_out_rebuild <= n_rebuild;
            r_out_no_slot <= n_no_slot;
            r_out_flush   <= n_flush;
            r_out_res     <= n_res;
            r_out_act     <= n_act;
        end
    end

    assign o_out.valid            = r_out_valid;
    assign o_out.slot             = r_out_slot;
    assign o_out.rebuild          = r_out_rebuild;
    assign o_out.no_slot          = r_out_no_slot;
    assign o_out.generation_flush = r_out_flush;
    assign o_out.resident_count   = r_out_res;
    assign o_out.active_count     = r_out_act;

    // active slots are always a subset of resident slots
    `TCCM_ASSERT(a_act_le_res, i_clk, i_rst_n, (r_act_cnt <= r_res_cnt),
                 "active count exceeds resident count")
    // a refused request leaves the slot and rebuild fields clear
    `TCCM_ASSERT(a_no_slot_clean, i_clk, i_rst_n,
                 (o_out.valid && o_out.no_slot) |-> (!o_out.rebuild && (o_out.slot == '0)),
                 "no_slot result with slot or rebuild set")
    // a finished begin sync leaves no slot active
    `TCCM_ASSERT(a_begin_clears, i_clk, i_rst_n,
                 (done_fire && (r_item.mode == MODE_BEGIN)) |=> ((r_act_cnt == '0) && (r_active == '0)),
                 "active marks survive begin sync")
    // the entry store is never written while a scan reads it
    `TCCM_ASSERT_ALWAYS(a_no_write_in_scan, i_clk, (r_state == ST_SCAN) |-> !mem_we,
                        "entry store written during scan")

endmodule

[sim/tb_tile_chunk_cache_manager_unit.sv]
// testbench for tile_chunk_cache_manager_unit: begin/request/end transactions
// checked against an in-bench model of the slot cache and its replacement
// depends on tccm_pkg, tccm_ifs and the rtl of the unit
`timescale 1ns / 1ps

module tb_tile_chunk_cache_manager_unit;
    import tccm_pkg::*;

    localparam int SLOTS = ENTRY_COUNT_DEF;
    localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;
    localparam int HOLD_CYCLES = 400;
    localparam int DRAIN_CYCLES = 60;
    localparam int TIMEOUT_NS = 2_000_000;
    localparam int ITEM_TARGET = 1100;
    localparam int POOL_SIZE = 48;

    typedef struct packed {
        logic [SLOT_W-1:0] slot;
        logic              rebuild;
        logic              no_slot;
        logic              generation_flush;
        logic [CNT_W-1:0]  resident_count;
        logic [CNT_W-1:0]  active_count;
    } t_cache_result;

    typedef enum logic [1:0] {RX_ALWAYS, RX_RANDOM, RX_SPARSE, RX_PERIODIC} t_rx_pattern;

    logic clk = 1'b0;
    logic rst_n;

    tccm_in_if  in_ch ();
    tccm_out_if out_ch ();

    tile_chunk_cache_manager_unit uut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    always #1 clk = ~clk;

    // model state of the slot cache
    logic             slot_valid  [SLOTS];
    logic             slot_active [SLOTS];
    logic [TAG_W-1:0] slot_tag    [SLOTS];
    logic [SIG_W-1:0] slot_sig    [SLOTS];
    logic [SEQ_W-1:0] slot_seen   [SLOTS];
    logic [GEN_W-1:0] held_map_gen;
    logic [GEN_W-1:0] held_rules_gen;
    logic [SEQ_W-1:0] cur_seq;

    t_cache_result pending_results[$];
    t_cache_result got_res;
    t_cache_result want_res;

    int mismatches = 0;
    int items_sent = 0;
    int req_count = 0;
    int hit_count = 0;
    int replace_count = 0;
    int full_count = 0;
    int flush_count = 0;
    int results_seen = 0;

    // sender pacing, owned by the main thread
    bit tx_gaps_on = 1'b0;
    int burst_left = 0;

    // receiver pattern and long hold-off request
    t_rx_pattern rx_mode = RX_ALWAYS;
    int hold_id = 0;

    // stimulus memory for the random part
    logic signed [COORD_W-1:0] pool_x [POOL_SIZE];
    logic signed [COORD_W-1:0] pool_y [POOL_SIZE];
    logic [SIG_W-1:0]          pool_sig [POOL_SIZE];
    logic [SEQ_W-1:0]          stim_seq = '0;

    function automatic void clear_cache_model();
        int i;
        for (i = 0; i < SLOTS; i++) begin
            slot_valid[i]  = 1'b0;
            slot_active[i] = 1'b0;
            slot_tag[i]    = '0;
            slot_sig[i]    = '0;
            slot_seen[i]   = '0;
        end
        held_map_gen   = '0;
        held_rules_gen = '0;
        cur_seq        = '0;
    endfunction

    function automatic t_cache_result predict_cache(input t_item it);
        t_cache_result res;
        logic [TAG_W-1:0] tag;
        int found;
        int oldest;
        int resident;
        int active;
        bit fresh;
        int i;
        res = '0;
        case (it.mode)
            MODE_BEGIN: begin
                if (it.map_generation != held_map_gen ||
                    it.rules_generation != held_rules_gen) begin
                    for (i = 0; i < SLOTS; i++) begin
                        slot_valid[i] = 1'b0;
                        slot_sig[i]   = '0;
                    end
                    held_map_gen   = it.map_generation;
                    held_rules_gen = it.rules_generation;
                    res.generation_flush = 1'b1;
                    flush_count++;
                end
                for (i = 0; i < SLOTS; i++)
                    slot_active[i] = 1'b0;
                cur_seq = it.sequence_req;
            end
            MODE_REQ: begin
                req_count++;
                tag    = {it.chunk_x, it.chunk_y};
                found  = -1;
                oldest = -1;
                fresh  = 1'b0;
                for (i = 0; i < SLOTS; i++)
                    if (found < 0 && slot_valid[i] && slot_tag[i] == tag)
                        found = i;
                if (found >= 0) begin
                    hit_count++;
                end else begin
                    fresh = 1'b1;
                    // first free slot wins; before it, track oldest inactive
                    for (i = 0; i < SLOTS; i++) begin
                        if (found < 0) begin
                            if (!slot_valid[i])
                                found = i;
                            else if (!slot_active[i] &&
                                     (oldest < 0 || slot_seen[i] < slot_seen[oldest]))
                                oldest = i;
                        end
                    end
                    if (found < 0 && oldest >= 0) begin
                        found = oldest;
                        replace_count++;
                    end
                end
                if (found < 0) begin
                    res.no_slot = 1'b1;
                    full_count++;
                end else begin
                    res.rebuild = fresh || (slot_sig[found] != it.content_signature) ||
                                  it.force_dirty;
                    slot_valid[found]  = 1'b1;
                    slot_tag[found]    = tag;
                    slot_sig[found]    = it.content_signature;
                    slot_active[found] = 1'b1;
                    slot_seen[found]   = cur_seq;
                    res.slot = SLOT_W'(found);
                end
            end
            MODE_END: begin
                resident = 0;
                active   = 0;
                for (i = 0; i < SLOTS; i++) begin
                    if (slot_valid[i])
                        resident++;
                    if (slot_active[i])
                        active++;
                end
                res.resident_count = CNT_W'(resident);
                res.active_count   = CNT_W'(active);
            end
            default: ;
        endcase
        return res;
    endfunction

    function automatic t_item random_fields();
        t_item it;
        it.mode              = MODE_W'($urandom_range(0, 3));
        it.map_generation    = $urandom;
        it.rules_generation  = $urandom;
        it.sequence_req      = {$urandom, $urandom};
        it.chunk_x           = COORD_W'($urandom);
        it.chunk_y           = COORD_W'($urandom);
        it.content_signature = {$urandom, $urandom};
        it.force_dirty       = 1'($urandom_range(0, 1));
        return it;
    endfunction

    // offer one transaction, wait for acceptance, then maybe pause
    task automatic send_item(input t_item it);
        int gap;
        in_ch.valid             <= 1'b1;
        in_ch.mode              <= it.mode;
        in_ch.map_generation    <= it.map_generation;
        in_ch.rules_generation  <= it.rules_generation;
        in_ch.sequence_req      <= it.sequence_req;
        in_ch.chunk_x           <= it.chunk_x;
        in_ch.chunk_y           <= it.chunk_y;
        in_ch.content_signature <= it.content_signature;
        in_ch.force_dirty       <= it.force_dirty;
        @(posedge clk);
        while (!in_ch.ready)
            @(posedge clk);
        pending_results.push_back(predict_cache(it));
        items_sent++;
        if (tx_gaps_on) begin
            if (burst_left == 0) begin
                burst_left = $urandom_range(1, 12);
                gap = $urandom_range(1, 6);
                in_ch.valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end else begin
                burst_left--;
            end
        end
    endtask

    task automatic send_begin(input logic [GEN_W-1:0] mg, input logic [GEN_W-1:0] rg,
                              input logic [SEQ_W-1:0] seq);
        t_item it;
        it = random_fields();
        it.mode             = MODE_BEGIN;
        it.map_generation   = mg;
        it.rules_generation = rg;
        it.sequence_req     = seq;
        send_item(it);
    endtask

    task automatic send_req(input logic signed [COORD_W-1:0] x,
                            input logic signed [COORD_W-1:0] y,
                            input logic [SIG_W-1:0] sig, input logic force_rebuild);
        t_item it;
        it = random_fields();
        it.mode              = MODE_REQ;
        it.chunk_x           = x;
        it.chunk_y           = y;
        it.content_signature = sig;
        it.force_dirty       = force_rebuild;
        send_item(it);
    endtask

    task automatic send_end();
        t_item it;
        it = random_fields();
        it.mode = MODE_END;
        send_item(it);
    endtask

    task automatic send_unused_mode();
        t_item it;
        it = random_fields();
        it.mode = MODE_UNUSED;
        send_item(it);
    endtask

    task automatic wait_drained();
        in_ch.valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // field extremes, hit/miss/rebuild rules, flushes and the unused mode
    task automatic test_directed();
        rx_mode    = RX_ALWAYS;
        tx_gaps_on = 1'b0;
        send_end();
        send_begin('0, '0, '0);
        send_req(-16'sd32768, 16'sd32767, '0, 1'b0);
        send_req(16'sd32767, -16'sd32768, '1, 1'b0);
        send_req(16'sd0, 16'sd0, '0, 1'b0);
        send_req(-16'sd1, -16'sd1, 64'd5, 1'b1);
        send_req(-16'sd32768, 16'sd32767, '0, 1'b0);
        send_req(16'sd32767, -16'sd32768, 64'h7FFF_FFFF_FFFF_FFFF, 1'b0);
        send_req(16'sd0, 16'sd0, '0, 1'b1);
        send_end();
        send_unused_mode();
        send_begin('0, '0, '1);
        send_end();
        send_req(-16'sd1, -16'sd1, 64'd5, 1'b0);
        send_begin('1, '0, 64'd1);
        send_end();
        send_req(-16'sd32768, 16'sd32767, '0, 1'b0);
        send_begin('1, '1, 64'd2);
        send_begin('1, '1, 64'd3);
        send_end();
        wait_drained();
    endtask

    // fill every slot in one sync, overflow it, then check tie and oldest choice
    task automatic test_capacity();
        logic signed [COORD_W-1:0] cap_y [SLOTS];
        int i;
        rx_mode    = RX_RANDOM;
        tx_gaps_on = 1'b1;
        send_begin(held_map_gen, held_rules_gen, 64'd10);
        for (i = 0; i < SLOTS; i++) begin
            cap_y[i] = COORD_W'($urandom);
            send_req(COORD_W'(i * 100 - 1800), cap_y[i], {$urandom, $urandom}, 1'b0);
        end
        send_req(16'sd1900, 16'sd7, '0, 1'b0);
        send_req(16'sd1900 - 16'sd1400, cap_y[5], '0, 1'b0);
        send_end();
        // every slot last seen at the same sequence: lowest index is taken
        send_begin(held_map_gen, held_rules_gen, 64'd10);
        send_req(16'sd2000, 16'sd1, 64'd1, 1'b0);
        send_req(16'sd2100, 16'sd2, 64'd2, 1'b0);
        send_end();
        send_begin(held_map_gen, held_rules_gen, 64'd3);
        send_req(COORD_W'(7 * 100 - 1800), cap_y[7], '0, 1'b0);
        send_end();
        send_begin(held_map_gen, held_rules_gen, 64'd4);
        send_req(16'sd2200, 16'sd3, 64'd3, 1'b1);
        send_end();
        wait_drained();
    endtask

    // one sync frame: begin, requests mostly from a reused pool, end
    task automatic random_sync();
        logic [GEN_W-1:0] mg;
        logic [GEN_W-1:0] rg;
        logic signed [COORD_W-1:0] x;
        logic signed [COORD_W-1:0] y;
        logic [SIG_W-1:0] sig;
        int r;
        int nreq;
        int k;
        int p;
        mg = held_map_gen;
        rg = held_rules_gen;
        r = $urandom_range(0, 99);
        if (r < 6)
            mg = mg + GEN_W'(1);
        else if (r < 9)
            rg = $urandom;
        else if (r < 11) begin
            mg = $urandom;
            rg = $urandom;
        end
        r = $urandom_range(0, 99);
        if (r < 70)
            stim_seq = stim_seq + SEQ_W'($urandom_range(1, 5));
        else if (r < 85)
            stim_seq = stim_seq;
        else if (r < 95)
            stim_seq = {$urandom, $urandom};
        else
            stim_seq = SEQ_W'($urandom_range(0, 3));
        send_begin(mg, rg, stim_seq);
        if ($urandom_range(0, 9) == 0)
            nreq = $urandom_range(30, 48);
        else
            nreq = $urandom_range(0, 16);
        for (k = 0; k < nreq; k++) begin
            if ($urandom_range(0, 4) != 0) begin
                p = $urandom_range(0, POOL_SIZE - 1);
                x = pool_x[p];
                y = pool_y[p];
                if ($urandom_range(0, 9) < 4)
                    pool_sig[p] = {$urandom, $urandom};
                sig = pool_sig[p];
            end else begin
                x = COORD_W'($urandom);
                y = COORD_W'($urandom);
                sig = {$urandom, $urandom};
            end
            send_req(x, y, sig, $urandom_range(0, 4) == 0);
        end
        // broken frame now and then: no end transaction
        if ($urandom_range(0, 11) != 0)
            send_end();
    endtask

    task automatic test_random_syncs();
        int i;
        int r;
        for (i = 0; i < POOL_SIZE; i++) begin
            pool_x[i]   = COORD_W'($urandom);
            pool_y[i]   = COORD_W'($urandom);
            pool_sig[i] = {$urandom, $urandom};
        end
        pool_x[0] = -16'sd32768; pool_y[0] = -16'sd32768;
        pool_x[1] = 16'sd32767;  pool_y[1] = 16'sd32767;
        pool_x[2] = -16'sd32768; pool_y[2] = 16'sd32767;
        pool_x[3] = 16'sd32767;  pool_y[3] = -16'sd32768;
        pool_x[4] = 16'sd0;      pool_y[4] = 16'sd0;
        pool_x[5] = -16'sd1;     pool_y[5] = -16'sd1;
        stim_seq = cur_seq;
        while (items_sent < ITEM_TARGET) begin
            rx_mode    = t_rx_pattern'($urandom_range(0, 3));
            tx_gaps_on = $urandom_range(0, 3) != 0;
            r = $urandom_range(0, 99);
            if (r < 4)
                send_item(random_fields());
            else if (r < 6)
                send_unused_mode();
            else
                random_sync();
        end
        wait_drained();
    endtask

    // long receiver hold-off while requests keep coming, so the input stalls
    task automatic test_backpressure();
        int k;
        rx_mode    = RX_ALWAYS;
        tx_gaps_on = 1'b0;
        hold_id++;
        send_begin(held_map_gen, held_rules_gen, cur_seq + 64'd1);
        for (k = 0; k < 28; k++)
            send_req(COORD_W'($urandom_range(0, 20)), COORD_W'($urandom_range(0, 1)),
                     SIG_W'($urandom_range(0, 2)), 1'b0);
        send_end();
        wait_drained();
    endtask

    // result checker
    always @(posedge clk) begin
        if (rst_n && out_ch.valid && out_ch.ready) begin
            results_seen++;
            got_res.slot             = out_ch.slot;
            got_res.rebuild          = out_ch.rebuild;
            got_res.no_slot          = out_ch.no_slot;
            got_res.generation_flush = out_ch.generation_flush;
            got_res.resident_count   = out_ch.resident_count;
            got_res.active_count     = out_ch.active_count;
            if (pending_results.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result transaction: ",
                             "slot=%0d rebuild=%0b no_slot=%0b flush=%0b res=%0d act=%0d",
                             got_res.slot, got_res.rebuild, got_res.no_slot,
                             got_res.generation_flush, got_res.resident_count,
                             got_res.active_count);
            end else begin
                want_res = pending_results.pop_front();
                if (got_res.slot !== want_res.slot || got_res.rebuild !== want_res.rebuild ||
                    got_res.no_slot !== want_res.no_slot ||
                    got_res.generation_flush !== want_res.generation_flush ||
                    got_res.resident_count !== want_res.resident_count ||
                    got_res.active_count !== want_res.active_count) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch at result %0d: ",
                                 "expected slot=%0d rebuild=%0b no_slot=%0b flush=%0b ",
                                 "res=%0d act=%0d, ",
                                 "got slot=%0d rebuild=%0b no_slot=%0b flush=%0b ",
                                 "res=%0d act=%0d",
                                 results_seen, want_res.slot, want_res.rebuild,
                                 want_res.no_slot, want_res.generation_flush,
                                 want_res.resident_count, want_res.active_count,
                                 got_res.slot, got_res.rebuild, got_res.no_slot,
                                 got_res.generation_flush, got_res.resident_count,
                                 got_res.active_count);
                end
            end
        end
    end

    // receiver: stall pattern plus the long hold-off
    initial begin : receiver
        int hold_left;
        int hold_seen;
        int rx_phase;
        hold_left = 0;
        hold_seen = 0;
        rx_phase  = 0;
        out_ch.ready <= 1'b0;
        forever begin
            @(posedge clk);
            if (hold_id != hold_seen) begin
                hold_seen = hold_id;
                hold_left = HOLD_CYCLES;
            end
            rx_phase = (rx_phase + 1) % 7;
            if (hold_left > 0) begin
                hold_left--;
                out_ch.ready <= 1'b0;
            end else begin
                case (rx_mode)
                    RX_ALWAYS:   out_ch.ready <= 1'b1;
                    RX_RANDOM:   out_ch.ready <= 1'($urandom_range(0, 1));
                    RX_SPARSE:   out_ch.ready <= ($urandom_range(0, 3) == 0);
                    RX_PERIODIC: out_ch.ready <= (rx_phase < 4);
                    default:     out_ch.ready <= 1'b1;
                endcase
            end
        end
    end

    initial begin
        #(TIMEOUT_NS);
        $display("timeout with %0d results outstanding", pending_results.size());
        $display("tb_tile_chunk_cache_manager_unit: FAIL");
        $finish;
    end

    initial begin
        clear_cache_model();
        rst_n                   <= 1'b0;
        in_ch.valid             <= 1'b0;
        in_ch.mode              <= MODE_BEGIN;
        in_ch.map_generation    <= '0;
        in_ch.rules_generation  <= '0;
        in_ch.sequence_req      <= '0;
        in_ch.chunk_x           <= '0;
        in_ch.chunk_y           <= '0;
        in_ch.content_signature <= '0;
        in_ch.force_dirty       <= 1'b0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        test_capacity();
        test_backpressure();
        test_random_syncs();

        $display("ran %0d transactions: %0d requests, %0d hits, %0d replacements, ",
                 "%0d full misses",
                 items_sent, req_count, hit_count, replace_count, full_count);
        $display("generation flushes: %0d, results checked: %0d, mismatches: %0d",
                 flush_count, results_seen, mismatches);
        if (mismatches == 0 && pending_results.size() == 0)
            $display("tb_tile_chunk_cache_manager_unit: PASS");
        else
            $display("tb_tile_chunk_cache_manager_unit: FAIL");
        $finish;
    end

endmodule

[tile_chunk_cache_manager_unit.f]
+incdir+src
src/tccm_pkg.sv
src/tccm_ifs.sv
src/tccm_mem.sv
src/tccm_scan.sv
src/tile_chunk_cache_manager_unit.sv
sim/tb_tile_chunk_cache_manager_unit.sv
